/* rtl/rotation_invariant_jet_matcher_assert.svh */
// Assertion macros shared by the jet matcher RTL.
`ifndef ROTATION_INVARIANT_JET_MATCHER_ASSERT_SVH
`define ROTATION_INVARIANT_JET_MATCHER_ASSERT_SVH
`ifndef SYNTHESIS
`define RIJM_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("assertion failed: condition must never hold");
`define RIJM_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");
`define RIJM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");
`else
`define RIJM_ASSERT_NEVER(lbl, cond)
`define RIJM_ASSERT_IMPLY(lbl, ante, cons)
`define RIJM_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* rtl/rijm_pkg.sv */
// Types and constants shared by the jet matcher modules.
`timescale 1ns / 1ps
package rijm_pkg;
  localparam logic [1:0] OP_WR_REF = 2'd0;
  localparam logic [1:0] OP_WR_QRY = 2'd1;
  localparam logic [1:0] OP_MATCH  = 2'd2;

  localparam logic [1:0] RS_WRITTEN  = 2'd0;
  localparam logic [1:0] RS_FULL     = 2'd1;
  localparam logic [1:0] RS_MATCH    = 2'd2;
  localparam logic [1:0] RS_NO_MATCH = 2'd3;

  localparam int Q_FRAC    = 15;
  localparam int SQ_STEPS  = 16;
  localparam int MUL_DIGIT = 8;

  typedef struct packed {
    logic [1:0]         op;
    logic [1:0]         scale_index;
    logic [2:0]         orient_index;
    logic signed [15:0] value;
    logic               last;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  best_entry;
    logic [15:0] best_score;
    logic [4:0]  entry_count;
  } out_item_t;

  typedef struct packed {
    logic item_acc;
    logic clr_acc;
    logic rd_en;
    logic mul_start;
    logic mul_step;
    logic sq_start;
    logic sq_step;
    logic score;
    logic clr_best;
    logic load_match;
  } dp_cmd_t;

  typedef struct packed {
    logic worthy;
    logic out_valid;
    logic no_entries;
    logic last_entry;
  } dp_stat_t;
endpackage

/* rtl/rijm_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module rijm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;
endmodule

/* rtl/rijm_ctrl.sv */
// Sequencer for the jet matcher: loops over entries, shifts and elements.
`timescale 1ns / 1ps
`include "rotation_invariant_jet_matcher_assert.svh"
module rijm_ctrl #(
  parameter int SCALES  = 4,
  parameter int ORIENTS = 8,
  parameter int ENTRIES = 16,
  localparam int JET = SCALES * ORIENTS,
  localparam int NW  = 31 + $clog2(JET),
  localparam int EW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
  localparam int SW  = (SCALES > 1) ? $clog2(SCALES) : 1,
  localparam int OW  = $clog2(ORIENTS)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic [1:0]         in_op,
  output logic               in_stall,
  input  logic               out_stall,
  input  rijm_pkg::dp_stat_t stat,
  output rijm_pkg::dp_cmd_t  cmd,
  output logic [EW-1:0]      e_idx,
  output logic [OW-1:0]      t_idx,
  output logic [SW-1:0]      s_idx,
  output logic [OW-1:0]      j_idx
);
  import rijm_pkg::*;

  localparam int MSTEPS     = (NW + MUL_DIGIT - 1) / MUL_DIGIT;
  localparam int DRAIN_LAST = 2;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ACC   = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_MUL   = 3'd3;
  localparam logic [2:0] S_SQI   = 3'd4;
  localparam logic [2:0] S_SQRT  = 3'd5;
  localparam logic [2:0] S_SCORE = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [2:0]    state_r, state_nxt;
  logic [EW-1:0] e_r, e_nxt;
  logic [OW-1:0] t_r, t_nxt;
  logic [SW-1:0] s_r, s_nxt;
  logic [OW-1:0] j_r, j_nxt;
  logic [3:0]    cnt_r, cnt_nxt;
  logic          out_busy;
  logic          accept;
  logic          advance;

  assign out_busy = stat.out_valid & out_stall;
  assign in_stall = (state_r != S_IDLE) | out_busy;
  assign accept   = in_valid & ~in_stall;

  always_comb begin
    state_nxt    = state_r;
    e_nxt        = e_r;
    t_nxt        = t_r;
    s_nxt        = s_r;
    j_nxt        = j_r;
    cnt_nxt      = cnt_r;
    advance      = 1'b0;
    cmd          = '0;
    cmd.item_acc = accept;
    case (state_r)
      S_IDLE: begin
        if (accept && in_op == OP_MATCH) begin
          cmd.clr_best = 1'b1;
          e_nxt        = '0;
          t_nxt        = '0;
          s_nxt        = '0;
          j_nxt        = '0;
          if (stat.no_entries) begin
            state_nxt = S_DONE;
          end else begin
            cmd.clr_acc = 1'b1;
            state_nxt   = S_ACC;
          end
        end
      end
      S_ACC: begin
        cmd.rd_en = 1'b1;
        if (j_r == OW'(ORIENTS - 1)) begin
          j_nxt = '0;
          if (s_r == SW'(SCALES - 1)) begin
            s_nxt     = '0;
            cnt_nxt   = '0;
            state_nxt = S_DRAIN;
          end else begin
            s_nxt = s_r + 1'b1;
          end
        end else begin
          j_nxt = j_r + 1'b1;
        end
      end
      S_DRAIN: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == 4'(DRAIN_LAST)) begin
          cnt_nxt = '0;
          if (stat.worthy) begin
            cmd.mul_start = 1'b1;
            state_nxt     = S_MUL;
          end else begin
            advance = 1'b1;
          end
        end
      end
      S_MUL: begin
        cmd.mul_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == 4'(MSTEPS - 1)) begin
          state_nxt = S_SQI;
        end
      end
      S_SQI: begin
        cmd.sq_start = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = S_SQRT;
      end
      S_SQRT: begin
        cmd.sq_step = 1'b1;
        cnt_nxt     = cnt_r + 1'b1;
        if (cnt_r == 4'(SQ_STEPS - 1)) begin
          state_nxt = S_SCORE;
        end
      end
      S_SCORE: begin
        cmd.score = 1'b1;
        advance   = 1'b1;
      end
      S_DONE: begin
        if (!out_busy) begin
          cmd.load_match = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (advance) begin
      if (t_r == OW'(ORIENTS - 1)) begin
        t_nxt = '0;
        if (stat.last_entry) begin
          state_nxt = S_DONE;
        end else begin
          e_nxt       = e_r + 1'b1;
          cmd.clr_acc = 1'b1;
          state_nxt   = S_ACC;
        end
      end else begin
        t_nxt       = t_r + 1'b1;
        cmd.clr_acc = 1'b1;
        state_nxt   = S_ACC;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      e_r     <= '0;
      t_r     <= '0;
      s_r     <= '0;
      j_r     <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      e_r     <= e_nxt;
      t_r     <= t_nxt;
      s_r     <= s_nxt;
      j_r     <= j_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  assign e_idx = e_r;
  assign t_idx = t_r;
  assign s_idx = s_r;
  assign j_idx = j_r;

  `RIJM_ASSERT_NEVER(a_mul_unworthy, cmd.mul_start && !stat.worthy)
  `RIJM_ASSERT_NEXT(a_done_idle, state_r == S_DONE && !out_busy, state_r == S_IDLE)
  `RIJM_ASSERT_NEVER(a_orient_range, 32'(t_r) >= ORIENTS || 32'(j_r) >= ORIENTS)
endmodule

/* rtl/rijm_dp.sv */
// Datapath of the jet matcher: stores, accumulators, multiplier and square-root search.
`timescale 1ns / 1ps
`include "rotation_invariant_jet_matcher_assert.svh"
module rijm_dp #(
  parameter int SCALES  = 4,
  parameter int ORIENTS = 8,
  parameter int ENTRIES = 16,
  localparam int JET = SCALES * ORIENTS,
  localparam int NW  = 31 + $clog2(JET),
  localparam int EW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
  localparam int SW  = (SCALES > 1) ? $clog2(SCALES) : 1,
  localparam int OW  = $clog2(ORIENTS)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  rijm_pkg::in_item_t  in_item,
  input  rijm_pkg::dp_cmd_t   cmd,
  input  logic [EW-1:0]       e_idx,
  input  logic [OW-1:0]       t_idx,
  input  logic [SW-1:0]       s_idx,
  input  logic [OW-1:0]       j_idx,
  input  logic                out_stall,
  output rijm_pkg::dp_stat_t  stat,
  output logic                out_valid,
  output rijm_pkg::out_item_t out_item
);
  import rijm_pkg::*;

  localparam int CW  = $clog2(ENTRIES + 1);
  localparam int AW  = $clog2(ENTRIES * JET);
  localparam int JW  = $clog2(JET);
  localparam int MW  = 2 * NW;
  localparam int SQW = 2 * NW + 32;

  // entry count and write side
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          full, in_range, is_ref, is_qry, ref_we, qry_we;
  logic [AW-1:0] ref_waddr, ref_raddr;
  logic [JW-1:0] qry_waddr, qry_raddr;
  logic [OW:0]   jt_sum, jt_wrap;

  assign full     = (cnt_r == CW'(ENTRIES));
  assign in_range = (32'(in_item.scale_index) < SCALES) &&
                    (32'(in_item.orient_index) < ORIENTS);
  assign is_ref   = cmd.item_acc && (in_item.op == OP_WR_REF);
  assign is_qry   = cmd.item_acc && (in_item.op == OP_WR_QRY);
  assign ref_we   = is_ref && !full && in_range;
  assign qry_we   = is_qry && in_range;
  assign ref_waddr = AW'(32'(cnt_r) * JET + 32'(in_item.scale_index) * ORIENTS
                         + 32'(in_item.orient_index));
  assign qry_waddr = JW'(32'(in_item.scale_index) * ORIENTS + 32'(in_item.orient_index));
  assign cnt_nxt  = (is_ref && !full && in_item.last) ? cnt_r + 1'b1 : cnt_r;

  // cyclic orientation shift of the reference read
  assign jt_sum    = {1'b0, j_idx} + {1'b0, t_idx};
  assign jt_wrap   = (32'(jt_sum) >= ORIENTS) ? jt_sum - (OW+1)'(ORIENTS) : jt_sum;
  assign ref_raddr = AW'(32'(e_idx) * JET + 32'(s_idx) * ORIENTS + 32'(jt_wrap));
  assign qry_raddr = JW'(32'(s_idx) * ORIENTS + 32'(j_idx));

  logic signed [15:0] r_rd, q_rd;

  rijm_ram #(.WIDTH(16), .DEPTH(ENTRIES * JET)) u_ref_ram (
    .clk   (clk),
    .we    (ref_we),
    .waddr (ref_waddr),
    .wdata (in_item.value),
    .raddr (ref_raddr),
    .rdata (r_rd)
  );

  rijm_ram #(.WIDTH(16), .DEPTH(JET)) u_qry_ram (
    .clk   (clk),
    .we    (qry_we),
    .waddr (qry_waddr),
    .wdata (in_item.value),
    .raddr (qry_raddr),
    .rdata (q_rd)
  );

  // products and sums
  logic               v1_r, v2_r;
  logic signed [31:0] pqr_r, pqq_r, prr_r;
  logic signed [NW:0] dot_r;
  logic [NW-1:0]      n1_r, n2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= cmd.rd_en;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    pqr_r <= q_rd * r_rd;
    pqq_r <= q_rd * q_rd;
    prr_r <= r_rd * r_rd;
    if (cmd.clr_acc) begin
      dot_r <= '0;
      n1_r  <= '0;
      n2_r  <= '0;
    end else if (v2_r) begin
      dot_r <= dot_r + (NW+1)'(pqr_r);
      n1_r  <= n1_r + NW'(pqq_r[30:0]);
      n2_r  <= n2_r + NW'(prr_r[30:0]);
    end
  end

  assign stat.worthy     = !dot_r[NW] && (dot_r != '0) && (n1_r != '0) && (n2_r != '0);
  assign stat.no_entries = (cnt_r == '0);
  assign stat.last_entry = (32'(e_idx) + 1 == 32'(cnt_r));

  // digit-serial products n1*n2 and dot*dot
  logic [MW-1:0] pa_r, da_r, pp_r, dd_r;
  logic [NW-1:0] pb_r, db_r;

  always_ff @(posedge clk) begin
    if (cmd.mul_start) begin
      pa_r <= MW'(n1_r);
      pb_r <= n2_r;
      da_r <= MW'(dot_r[NW-1:0]);
      db_r <= dot_r[NW-1:0];
      pp_r <= '0;
      dd_r <= '0;
    end else if (cmd.mul_step) begin
      pp_r <= pp_r + pa_r * MW'(pb_r[MUL_DIGIT-1:0]);
      dd_r <= dd_r + da_r * MW'(db_r[MUL_DIGIT-1:0]);
      pa_r <= pa_r << MUL_DIGIT;
      da_r <= da_r << MUL_DIGIT;
      pb_r <= pb_r >> MUL_DIGIT;
      db_r <= db_r >> MUL_DIGIT;
    end
  end

  // bit-by-bit search for the largest k with k*k*n1*n2 <= dot*dot*2^30,
  // squares kept incrementally so each step is an add and a compare
  logic [SQW-1:0]      k2p_r, kpb_r, pbs_r, d_r, cand;
  logic                take;
  logic [SQ_STEPS-1:0] k_r;

  assign cand = k2p_r + kpb_r + pbs_r;
  assign take = (cand <= d_r);

  always_ff @(posedge clk) begin
    if (cmd.sq_start) begin
      k2p_r <= '0;
      kpb_r <= '0;
      pbs_r <= SQW'(pp_r) << (2 * (SQ_STEPS - 1));
      d_r   <= SQW'(dd_r) << (2 * Q_FRAC);
      k_r   <= '0;
    end else if (cmd.sq_step) begin
      if (take) begin
        k2p_r <= cand;
        kpb_r <= (kpb_r >> 1) + pbs_r;
      end else begin
        kpb_r <= kpb_r >> 1;
      end
      pbs_r <= pbs_r >> 2;
      k_r   <= {k_r[SQ_STEPS-2:0], take};
    end
  end

  // best so far
  logic [15:0]   best_r;
  logic [EW-1:0] best_e_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_r   <= '0;
      best_e_r <= '0;
    end else if (cmd.clr_best) begin
      best_r   <= '0;
      best_e_r <= '0;
    end else if (cmd.score && (k_r > best_r)) begin
      best_r   <= k_r;
      best_e_r <= e_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // output register
  logic      out_valid_r;
  logic      load_item, load;
  out_item_t out_item_r, out_item_nxt;

  assign load_item = cmd.item_acc && (in_item.op != OP_MATCH);
  assign load      = load_item || cmd.load_match;

  always_comb begin
    out_item_nxt = '0;
    if (cmd.load_match) begin
      out_item_nxt.status      = (best_r != '0) ? RS_MATCH : RS_NO_MATCH;
      out_item_nxt.best_entry  = 4'(best_e_r);
      out_item_nxt.best_score  = best_r;
      out_item_nxt.entry_count = 5'(cnt_r);
    end else begin
      out_item_nxt.status      = (is_ref && full) ? RS_FULL : RS_WRITTEN;
      out_item_nxt.entry_count = 5'(cnt_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign stat.out_valid = out_valid_r;
  assign out_valid      = out_valid_r;
  assign out_item       = out_item_r;

  `RIJM_ASSERT_NEVER(a_load_over_held, out_valid_r && out_stall && load)
  `RIJM_ASSERT_NEVER(a_score_cap, best_r > 16'(1 << Q_FRAC))
  `RIJM_ASSERT_NEVER(a_count_cap, 32'(cnt_r) > ENTRIES)
  `RIJM_ASSERT_IMPLY(a_write_idle, ref_we || qry_we, !v1_r && !v2_r)
endmodule

/* rtl/rotation_invariant_jet_matcher.sv */
// Top level of the rotation-invariant jet matcher.
`timescale 1ns / 1ps
// Usage:
//   Input channel in_valid/in_stall/in_item carries one op per item: append a
//   reference jet element (last closes the entry), write a query element, or
//   match the query against all closed entries.
//   Output channel out_valid/out_stall/out_item returns one result per item.
// Flow and rate:
//   Write items: result registered on acceptance; one item per
//   cycle while the receiver keeps up.
//   Match items: per closed entry and per orientation shift, the
//   SCALES*ORIENTS element reads (one RAM read port per store), then
//   the pipeline drain; a shift with a positive dot product then
//   runs 8-bit digit-serial products and a 16-step
//   square-root search. The input is stalled for the whole walk.
// Reset: synchronous active-low rst_n clears the entry count and the
//   controller; the jet stores are not cleared and must be written before use.
// Back-pressure: a held result stays in the output register while out_stall
//   is high, and the input is stalled until it leaves.
module rotation_invariant_jet_matcher #(
  parameter int SCALES  = 4,
  parameter int ORIENTS = 8,
  parameter int ENTRIES = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  rijm_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output rijm_pkg::out_item_t out_item
);
  import rijm_pkg::*;

  localparam int EW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int SW = (SCALES > 1) ? $clog2(SCALES) : 1;
  localparam int OW = $clog2(ORIENTS);

  dp_cmd_t       cmd;
  dp_stat_t      stat;
  logic [EW-1:0] e_idx;
  logic [OW-1:0] t_idx;
  logic [SW-1:0] s_idx;
  logic [OW-1:0] j_idx;

  // controller: handshake and loop sequencing
  rijm_ctrl #(.SCALES(SCALES), .ORIENTS(ORIENTS), .ENTRIES(ENTRIES)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_op     (in_item.op),
    .in_stall  (in_stall),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd),
    .e_idx     (e_idx),
    .t_idx     (t_idx),
    .s_idx     (s_idx),
    .j_idx     (j_idx)
  );

  // datapath: stores, arithmetic and the output register
  rijm_dp #(.SCALES(SCALES), .ORIENTS(ORIENTS), .ENTRIES(ENTRIES)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (cmd),
    .e_idx     (e_idx),
    .t_idx     (t_idx),
    .s_idx     (s_idx),
    .j_idx     (j_idx),
    .out_stall (out_stall),
    .stat      (stat),
    .out_valid (out_valid),
    .out_item  (out_item)
  );
endmodule
